// ----- hw/rtl/uart_baud_divisor_solver_unit_macros.svh -----
// Assertion macros used by the solver unit.
`ifndef UART_BAUD_DIVISOR_SOLVER_UNIT_MACROS_SVH
`define UART_BAUD_DIVISOR_SOLVER_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define UBDS_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication checked outside reset.
`define UBDS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ----- hw/rtl/ubds_pkg.sv -----
package ubds_pkg;

  localparam int BaudW  = 24;
  localparam int ClkW   = 32;
  localparam int QuotW  = 17;
  localparam int DivW   = 16;
  localparam int CntW   = 9;
  localparam int DenW   = BaudW + DivW;
  // Both long divisions use a row of cells, one quotient bit per cell.
  localparam int QuotCells = QuotW;
  localparam int CntCells  = CntW;
  localparam int RemW      = 42;
  // Registers from the input capture to the result register.
  localparam int Stages    = 1 + QuotCells + 2 + CntCells + 1;

  localparam logic [DivW-1:0] DivisorMax = 16'hffff;
  localparam logic [CntW-1:0] CountMin   = 9'd2;
  localparam logic [CntW-1:0] CountMax   = 9'd256;

  // One cell's data word. The same layout serves both divisions.
  typedef struct packed {
    logic            live;
    logic            ok;
    logic            sat;
    logic [BaudW-1:0] baud;
    logic [ClkW-1:0] rclk;
    logic [RemW-1:0] num;
    logic [RemW-1:0] rem;
    logic [RemW-1:0] den;
    logic [QuotW-1:0] quot;
    logic [DivW-1:0] divisor;
  } cell_t;

endpackage

// ----- hw/rtl/ubds_div_cell.sv -----
// One restoring-division step: takes the next numerator bit in and decides
// one quotient bit.
module ubds_div_cell import ubds_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t d,
  output cell_t q
);

  logic [RemW-1:0] trial;
  logic            fits;
  cell_t           nxt;

  always_comb begin
    nxt   = d;
    trial = {d.rem[RemW-2:0], d.num[RemW-1]};
    fits  = trial >= d.den;
    nxt.num  = {d.num[RemW-2:0], 1'b0};
    nxt.rem  = fits ? trial - d.den : trial;
    nxt.quot = {d.quot[QuotW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.live <= 1'b0;
    end else if (en) begin
      q.live <= d.live;
    end
    if (en) begin
      q.ok      <= nxt.ok;
      q.sat     <= nxt.sat;
      q.baud    <= nxt.baud;
      q.rclk    <= nxt.rclk;
      q.num     <= nxt.num;
      q.rem     <= nxt.rem;
      q.den     <= nxt.den;
      q.quot    <= nxt.quot;
      q.divisor <= nxt.divisor;
    end
  end

endmodule

// ----- hw/rtl/uart_baud_divisor_solver_unit.sv -----
// Baud divisor solver. Each requested_baud beat gives one result beat. The
// pipeline is a chain of registered division cells: 17 cells find the
// divisor from the reference clock, a multiplier stage forms divisor*baud,
// and 9 more cells find the rounded oversampling count. One beat enters per
// cycle; the count cells feed the result register, and the whole chain
// stalls while the output beat is not taken.
module uart_baud_divisor_solver_unit import ubds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ClkW-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BaudW-1:0]  requested_baud,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              settings_valid,
  output logic [DivW-1:0]   clock_divisor,
  output logic [7:0]        sample_count_value,
  output logic [6:0]        sample_point_value
);

`include "uart_baud_divisor_solver_unit_macros.svh"

  logic [ClkW-1:0] rclk;
  logic            en;
  cell_t           s0, s1;
  cell_t           qa [QuotCells+1];
  cell_t           m0, m1;
  cell_t           ca [CntCells+1];
  logic [QuotW-1:0] q17;
  logic [DivW-1:0]  dsat;
  logic [DenW-1:0]  den_prod;
  logic [RemW-1:0]  dnum;
  logic [RemW-1:0]  cnum;
  logic [CntW-1:0]  cnt;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rclk <= '0;
    end else if (cfg_valid) begin
      rclk <= cfg_data;
    end
  end

  // Stage 0: capture and form numerator rclk + span - 1, span = baud*256.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.live <= 1'b0;
    end else if (en) begin
      s0.live <= in_valid;
    end
    if (en) begin
      s0.baud    <= requested_baud;
      s0.rclk    <= rclk;
      s0.ok      <= (requested_baud != '0) && (rclk != '0);
      s0.sat     <= 1'b0;
      s0.num     <= '0;
      s0.rem     <= '0;
      s0.den     <= '0;
      s0.quot    <= '0;
      s0.divisor <= '0;
    end
  end

  // The cells only produce the low 17 quotient bits. The upper numerator
  // bits preload the remainder; if they already reach the denominator, the
  // quotient is too large and the divisor saturates.
  always_comb begin
    s1 = s0;
    s1.den  = RemW'({s0.baud, 8'd0});
    dnum    = RemW'(s0.rclk) + s1.den - RemW'(1);
    s1.num  = dnum << (RemW - QuotW);
    s1.rem  = dnum >> QuotW;
    s1.sat  = (dnum >> QuotW) >= s1.den;
    s1.quot = '0;
    s1.divisor = '0;
  end

  assign qa[0] = s1;

  for (genvar i = 0; i < QuotCells; i++) begin : g_q
    ubds_div_cell u_cell (.clk(clk), .rst(rst), .en(en), .d(qa[i]), .q(qa[i+1]));
  end

  // Clamp the divisor and register it.
  assign q17  = qa[QuotCells].quot;
  assign dsat = (qa[QuotCells].sat || q17[QuotW-1]) ? DivisorMax :
                ((q17 == '0) ? DivW'(1) : q17[DivW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m0.live <= 1'b0;
    end else if (en) begin
      m0.live <= qa[QuotCells].live;
    end
    if (en) begin
      m0.ok      <= qa[QuotCells].ok;
      m0.sat     <= 1'b0;
      m0.baud    <= qa[QuotCells].baud;
      m0.rclk    <= qa[QuotCells].rclk;
      m0.divisor <= dsat;
      m0.num     <= '0;
      m0.rem     <= '0;
      m0.den     <= '0;
      m0.quot    <= '0;
    end
  end

  // Multiplier stage: denominator = divisor * baud.
  assign den_prod = DenW'(m0.divisor) * DenW'(m0.baud);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1.live <= 1'b0;
    end else if (en) begin
      m1.live <= m0.live;
    end
    if (en) begin
      m1.ok      <= m0.ok;
      m1.sat     <= 1'b0;
      m1.baud    <= m0.baud;
      m1.rclk    <= m0.rclk;
      m1.divisor <= m0.divisor;
      m1.den     <= RemW'(den_prod);
      m1.num     <= '0;
      m1.rem     <= '0;
      m1.quot    <= '0;
    end
  end

  // An unsaturated divisor keeps the rounded count at or below 256, but a
  // saturated one can give a much larger count, which the preloaded
  // remainder or the final compare flags so that the count saturates.
  always_comb begin
    ca[0] = m1;
    cnum  = RemW'(m1.rclk) + (m1.den >> 1);
    ca[0].num = cnum << (RemW - CntW);
    ca[0].rem = cnum >> CntW;
    ca[0].sat = (cnum >> CntW) >= m1.den;
  end

  for (genvar j = 0; j < CntCells; j++) begin : g_c
    ubds_div_cell u_cell (.clk(clk), .rst(rst), .en(en), .d(ca[j]), .q(ca[j+1]));
  end

  always_comb begin
    cnt = ca[CntCells].quot[CntW-1:0];
    if (ca[CntCells].sat || ca[CntCells].quot[QuotW-1:CntW] != '0 || cnt > CountMax) begin
      cnt = CountMax;
    end else if (cnt < CountMin) begin
      cnt = CountMin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ca[CntCells].live;
    end
    if (en) begin
      settings_valid     <= ca[CntCells].ok;
      clock_divisor      <= ca[CntCells].ok ? ca[CntCells].divisor : '0;
      sample_count_value <= ca[CntCells].ok ? 8'(cnt - CntW'(1)) : '0;
      sample_point_value <= ca[CntCells].ok ? 7'((cnt - CountMin) >> 1) : '0;
    end
  end

  `UBDS_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(clock_divisor), "result changed while stalled")
  `UBDS_ASSERT_IMP(a_div_nz, clk, rst, out_valid && settings_valid, clock_divisor != '0, "zero divisor on valid settings")
  `UBDS_ASSERT_IMP(a_cnt_min, clk, rst, out_valid && settings_valid, sample_count_value != '0, "count below minimum")
  `UBDS_ASSERT_IMP(a_invalid_zero, clk, rst, out_valid && !settings_valid, clock_divisor == '0 && sample_count_value == '0, "invalid result not zeroed")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb import ubds_pkg::*; ();

  localparam int LatencyCycles = Stages;
  localparam int RandomBeats   = 1900;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic       ok;
    logic [15:0] divisor;
    logic [7:0]  count_reg;
    logic [6:0]  point_reg;
  } settings_t;

  typedef struct {
    logic [BaudW-1:0] baud;
    logic             known;
    settings_t        want;
  } baud_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ClkW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BaudW-1:0]  requested_baud = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              settings_valid;
  logic [DivW-1:0]   clock_divisor;
  logic [7:0]        sample_count_value;
  logic [6:0]        sample_point_value;

  logic [31:0] ref_clock_hz = '0;
  settings_t   pending_settings[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  bit          hold_off = 1'b0;
  bit          long_hold_req = 1'b0;

  uart_baud_divisor_solver_unit i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready,
    .requested_baud, .out_valid, .out_ready, .settings_valid, .clock_divisor,
    .sample_count_value, .sample_point_value
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic settings_t solve_settings(logic [BaudW-1:0] baud, logic [31:0] rclk);
    settings_t r;
    logic [63:0] span;
    logic [63:0] div;
    logic [63:0] den;
    logic [63:0] cnt;
    r = '{1'b0, '0, '0, '0};
    if (baud == 0 || rclk == 0) return r;
    span = 64'(baud) * 256;
    div = (64'(rclk) + span - 1) / span;
    if (div < 1) div = 1;
    if (div > 64'hffff) div = 64'hffff;
    den = div * 64'(baud);
    cnt = (64'(rclk) + den / 2) / den;
    if (cnt < 2) cnt = 2;
    if (cnt > 256) cnt = 256;
    r.ok = 1'b1;
    r.divisor = div[15:0];
    r.count_reg = 8'(cnt - 1);
    r.point_reg = 7'((cnt - 2) >> 1);
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_ref_clock(logic [31:0] hz);
    in_valid <= 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    ref_clock_hz = hz;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(negedge clk);
    idle_cycles(LatencyCycles + 4);
  endtask

  // One request beat; with a zero gap it follows the previous beat directly.
  // The task returns at a falling edge with valid still high.
  task automatic send_baud(logic [BaudW-1:0] baud, int gap, bit known, settings_t want);
    settings_t exp_s;
    if (gap != 0) begin
      in_valid <= 1'b0;
      idle_cycles(gap);
    end
    in_valid       <= 1'b1;
    requested_baud <= baud;
    do @(posedge clk); while (!in_ready);
    exp_s = solve_settings(baud, ref_clock_hz);
    if (known && exp_s != want) begin
      $error("directed row baud=%0d disagrees with predictor", baud);
      error_count++;
    end
    pending_settings.push_back(exp_s);
    @(negedge clk);
  endtask

  // Receiver side.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        long_hold_req = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (hold_off) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    settings_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_settings.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        e = pending_settings.pop_front();
        if (settings_valid !== e.ok) begin
          $error("settings_valid exp %0d got %0d", e.ok, settings_valid);
          error_count++;
        end
        if (clock_divisor !== e.divisor) begin
          $error("clock_divisor exp %0d got %0d", e.divisor, clock_divisor);
          error_count++;
        end
        if (sample_count_value !== e.count_reg) begin
          $error("sample_count_value exp %0d got %0d", e.count_reg, sample_count_value);
          error_count++;
        end
        if (sample_point_value !== e.point_reg) begin
          $error("sample_point_value exp %0d got %0d", e.point_reg, sample_point_value);
          error_count++;
        end
      end
    end
  end

  function automatic logic [BaudW-1:0] pick_baud();
    case ($urandom_range(0, 5))
      0: return BaudW'($urandom);
      1: return BaudW'($urandom_range(1, 255));
      2: return BaudW'($urandom_range(1, 20000));
      3: return BaudW'($urandom_range(9600, 4000000));
      4: return BaudW'(1 << $urandom_range(0, 23));
      default: return BaudW'($urandom_range(16777000, 16777215));
    endcase
  endfunction

  initial begin
    baud_row_t rows[$];
    settings_t none;
    logic [31:0] clk_set[6];
    int n;
    none = '{1'b0, '0, '0, '0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Clock unknown after reset: nothing programmed.
    send_baud(24'd115200, 0, 1'b1, none);
    send_baud(24'hffffff, 0, 1'b1, none);
    drain_results();

    write_ref_clock(32'hffffffff);
    rows.push_back('{24'd0, 1'b1, none});
    rows.push_back('{24'd1, 1'b1, '{1'b1, 16'hffff, 8'd255, 7'd127}}); // slow: saturates
    rows.push_back('{24'hffffff, 1'b0, none});
    rows.push_back('{24'd115200, 1'b0, none});
    rows.push_back('{24'h800000, 1'b0, none});
    rows.push_back('{24'h7fffff, 1'b0, none});
    foreach (rows[i]) send_baud(rows[i].baud, i % 3, rows[i].known, rows[i].want);
    drain_results();

    write_ref_clock(32'd1);
    send_baud(24'd1, 0, 1'b1, '{1'b1, 16'd1, 8'd1, 7'd0}); // fast: count raised to 2
    send_baud(24'hffffff, 1, 1'b0, none);
    drain_results();

    write_ref_clock(32'd0);
    send_baud(24'd9600, 0, 1'b1, none);
    drain_results();

    write_ref_clock(32'd26000000);
    foreach (rows[i]) send_baud(rows[i].baud, 0, 1'b0, none);
    send_baud(24'd300, 0, 1'b0, none);
    send_baud(24'd3000000, 0, 1'b0, none);
    drain_results();

    // Back-pressure: receiver stalls while requests keep coming.
    long_hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_baud(pick_baud(), 0, 1'b0, none);
    drain_results();

    clk_set[0] = 32'hffffffff;
    clk_set[1] = 32'd1843200;
    clk_set[2] = 32'd48000000;
    clk_set[3] = 32'd1;
    clk_set[4] = 32'd0;
    clk_set[5] = 32'h80000000;
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_ref_clock(ph < 6 ? clk_set[ph] : $urandom);
      hold_off = (ph == 2);
      for (int i = 0; i < RandomBeats / 8; i++) begin
        send_baud(pick_baud(), (ph == 2 || $urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(0, 11), 1'b0, none);
        n++;
      end
      hold_off = 1'b0;
      drain_results();
    end

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ubds_pkg.sv
hw/rtl/ubds_div_cell.sv
hw/rtl/uart_baud_divisor_solver_unit.sv
verif/tb.sv
